### design/acsm_pkg.sv
// Shared types, codes and helpers for the acrostic substring match block.
// No dependencies; every other file except acsm_checker.sv imports this package.
package acsm_pkg;

   // Field widths fixed by the item formats
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 16;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [COUNT_W-1:0]  count_type;

   // Opcodes
   localparam opcode_type OP_SENTENCE = 2'd0;
   localparam opcode_type OP_DICT     = 2'd1;
   localparam opcode_type OP_CLEAR    = 2'd2;

   localparam char_type  SPACE_BYTE = 8'h20;
   localparam char_type  NO_LETTER  = 8'h00;
   localparam count_type COUNT_MAX  = 16'hFFFF;

   // Fan-in of one OR-reduction node
   localparam int TREE_RADIX = 16;

   // Commands broadcast to every cell in the chain
   typedef struct packed {
      logic     clear;       // drop all letters and live bits
      logic     alloc;       // first free cell takes a new word
      logic     set_letter;  // a letter is recorded for the newest word
      logic     step;        // dictionary byte advances the live bits
      logic     first;       // the dictionary byte opens a word
      char_type letter;      // lowercased byte of the current item
   } cell_ctl_type;

   // Finished dictionary word travelling toward the output
   typedef struct packed {
      logic      valid;
      count_type word_number;
      count_type word_size;
      logic      overflowed;
   } tag_type;

   function automatic logic is_letter(input char_type c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic char_type to_lower(input char_type c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? char_type'(c + 8'h20) : c;
   endfunction

   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? v : count_type'(v + 16'd1);
   endfunction

   // Register levels of the OR tree over a given number of live bits
   function automatic int tree_levels(input int width);
      int w;
      int n;
      w = width;
      n = 1;
      while (w > TREE_RADIX) begin
         w = (w + TREE_RADIX - 1) / TREE_RADIX;
         n++;
      end
      return n;
   endfunction

endpackage

### design/acsm_ifs.sv
// Channel interfaces: byte input channel and word result channel.
// Depends on acsm_pkg.
interface acsm_req_if;
   import acsm_pkg::*;
   logic       valid;
   logic       ready;
   opcode_type opcode;
   char_type   char_byte;
   logic       line_end;

   modport source (output valid, opcode, char_byte, line_end, input ready);
   modport sink   (input valid, opcode, char_byte, line_end, output ready);
endinterface

interface acsm_rsp_if;
   import acsm_pkg::*;
   logic      valid;
   logic      ready;
   count_type word_number;
   count_type word_size;
   logic      found;
   logic      letters_overflowed;

   modport source (output valid, word_number, word_size, found, letters_overflowed,
                   input ready);
   modport sink   (input valid, word_number, word_size, found, letters_overflowed,
                   output ready);
endinterface

### design/acsm_cell.sv
// One cell of the letter chain: an initial letter, an occupied flag and
// one Shift-And live bit. Depends on acsm_pkg.
module acsm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  acsm_pkg::cell_ctl_type ctl,
   input  logic                 occ_prev,   // left neighbor occupied (1 at head)
   input  logic                 occ_next,   // right neighbor occupied (0 at end)
   input  logic                 live_prev,  // left neighbor live bit (0 at head)
   output logic                 occ,
   output logic                 live
);
   import acsm_pkg::*;

   logic     occ_ff, occ_in;
   logic     live_ff, live_in;
   char_type letter_ff, letter_in;
   logic     free_head;
   logic     tail;
   logic     hit;

   // Occupied cells form a prefix, so neighbors locate the write point
   assign free_head = !occ_ff && occ_prev;
   assign tail      = occ_ff && !occ_next;
   assign hit       = occ_ff && (letter_ff != NO_LETTER) && (letter_ff == ctl.letter);

   // Next state
   always_comb begin
      occ_in    = occ_ff;
      live_in   = live_ff;
      letter_in = letter_ff;
      if (ctl.clear) begin
         occ_in  = 1'b0;
         live_in = 1'b0;
      end else begin
         if (ctl.alloc && free_head) begin
            occ_in    = 1'b1;
            letter_in = ctl.set_letter ? ctl.letter : NO_LETTER;
         end else if (ctl.set_letter && !ctl.alloc && tail) begin
            letter_in = ctl.letter;
         end
         if (ctl.step) begin
            live_in = hit && (ctl.first || live_prev);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= 1'b0;
         live_ff <= 1'b0;
      end else begin
         occ_ff  <= occ_in;
         live_ff <= live_in;
      end
   end

   // Letter needs no reset: it is read only once the cell is occupied
   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
   end

   assign occ  = occ_ff;
   assign live = live_ff;

endmodule

### design/acsm_or_tree.sv
// Registered OR reduction of the live bits, a register at each level, radix 16.
// Recurses on itself for wide inputs. Depends on acsm_pkg.
module acsm_or_tree #(
   parameter int WIDTH = 256
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] bits_in,
   output logic             any_out
);
   import acsm_pkg::*;

   localparam int GROUPS = (WIDTH + TREE_RADIX - 1) / TREE_RADIX;

   generate
      if (WIDTH <= TREE_RADIX) begin : g_leaf
         logic any_ff;
         always_ff @(posedge clock) begin
            if (enable) begin
               any_ff <= |bits_in;
            end
         end
         assign any_out = any_ff;
      end else begin : g_node
         logic [GROUPS*TREE_RADIX-1:0] padded;
         logic [GROUPS-1:0]            group_ff;

         assign padded = (GROUPS*TREE_RADIX)'(bits_in);

         // One OR per group of cells
         always_ff @(posedge clock) begin
            if (enable) begin
               for (int g = 0; g < GROUPS; g++) begin
                  group_ff[g] <= |padded[g*TREE_RADIX +: TREE_RADIX];
               end
            end
         end

         acsm_or_tree #(.WIDTH(GROUPS)) u_next (
            .clock   (clock),
            .enable  (enable),
            .bits_in (group_ff),
            .any_out (any_out)
         );
      end
   endgenerate

endmodule

### design/acrostic_substring_match_top.sv
// Acrostic substring match: word splitter and control, a chain of letter
// cells, a pipelined OR tree and a skid-buffered result stage.
// Depends on acsm_pkg, acsm_ifs, acsm_cell and acsm_or_tree.
//
// Usage: req_chan carries one byte item per handshake (opcode, char_byte,
// line_end). Sentence bytes record the first letter of each word in the next
// free cell; dictionary bytes advance the Shift-And live bit in every cell at
// once. Each finished dictionary word (space, or line_end on the last byte)
// produces one rsp_chan item: word_number, word_size, found and
// letters_overflowed. A clear opcode empties the chain and all counters.
//
// Throughput: one item per cycle while the skid stage is empty; every cell
// updates in the same cycle. Each word-ending item's tag passes through tag
// stages 0 to TREE_LEVELS, in step with the registered radix-16 OR tree that
// reduces the live bits, and then through the output register.
// Stall: results queue in an output register plus a one-entry skid stage;
// req_chan.ready drops only while the skid stage holds a result, and the
// whole pipeline freezes until rsp_chan takes one.
// Reset: synchronous, clears the chain, counters and all valid flags;
// req_chan.ready is high on the first cycle after reset.
module acrostic_substring_match_top #(
   parameter int LETTER_DEPTH = 256
) (
   input logic      clock,
   input logic      reset,
   acsm_req_if.sink req_chan,
   acsm_rsp_if.source rsp_chan
);
   import acsm_pkg::*;

   localparam int TREE_LEVELS = tree_levels(LETTER_DEPTH);

   // Word splitter and dictionary state
   logic      sentence_in_word_ff, sentence_in_word_in;
   logic      letter_taken_ff, letter_taken_in;
   logic      dict_in_word_ff, dict_in_word_in;
   logic      overflow_seen_ff, overflow_seen_in;
   count_type dict_word_count_ff, dict_word_count_in;
   count_type dict_char_count_ff, dict_char_count_in;

   logic [LETTER_DEPTH-1:0] occ;
   logic [LETTER_DEPTH-1:0] live;

   cell_ctl_type ctl;
   tag_type      tag_ff [0:TREE_LEVELS];
   tag_type      new_tag;

   logic      advance;
   logic      accept;
   logic      is_space;
   logic      full;
   logic      sent, dict;
   logic      new_word, taken_eff;
   logic      step, finish;
   count_type char_count_upd;
   logic      tree_any;

   // Output register and skid stage
   logic      out_valid_ff;
   tag_type   out_tag_ff;
   logic      out_found_ff;
   logic      skid_valid_ff;
   tag_type   skid_tag_ff;
   logic      skid_found_ff;

   assign advance        = !skid_valid_ff;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_space       = (req_chan.char_byte == SPACE_BYTE);
   assign full           = occ[LETTER_DEPTH-1];

   // Decode of the current item
   always_comb begin
      sent           = accept && (req_chan.opcode == OP_SENTENCE);
      dict           = accept && (req_chan.opcode == OP_DICT);
      new_word       = sent && !is_space && !sentence_in_word_ff;
      taken_eff      = new_word ? full : letter_taken_ff;
      step           = dict && !is_space;
      finish         = dict && (is_space ? dict_in_word_ff : req_chan.line_end);
      char_count_upd = step ? sat_inc(dict_char_count_ff) : dict_char_count_ff;

      ctl.clear      = accept && (req_chan.opcode == OP_CLEAR);
      ctl.alloc      = new_word && !full;
      ctl.set_letter = sent && !is_space && !taken_eff && is_letter(req_chan.char_byte);
      ctl.step       = step;
      ctl.first      = !dict_in_word_ff;
      ctl.letter     = to_lower(req_chan.char_byte);
   end

   // Control next state
   always_comb begin
      sentence_in_word_in = sentence_in_word_ff;
      letter_taken_in     = letter_taken_ff;
      overflow_seen_in    = overflow_seen_ff;
      dict_in_word_in     = dict_in_word_ff;
      dict_word_count_in  = dict_word_count_ff;
      dict_char_count_in  = dict_char_count_ff;
      if (ctl.clear) begin
         sentence_in_word_in = 1'b0;
         letter_taken_in     = 1'b0;
         overflow_seen_in    = 1'b0;
         dict_in_word_in     = 1'b0;
         dict_word_count_in  = '0;
         dict_char_count_in  = '0;
      end else begin
         if (sent) begin
            sentence_in_word_in = !is_space && !req_chan.line_end;
            if (!is_space) begin
               letter_taken_in = taken_eff || ctl.set_letter;
            end
            if (new_word && full) begin
               overflow_seen_in = 1'b1;
            end
         end
         if (step) begin
            dict_in_word_in    = 1'b1;
            dict_char_count_in = char_count_upd;
         end
         if (finish) begin
            dict_in_word_in    = 1'b0;
            dict_char_count_in = '0;
            dict_word_count_in = sat_inc(dict_word_count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sentence_in_word_ff <= 1'b0;
         letter_taken_ff     <= 1'b0;
         overflow_seen_ff    <= 1'b0;
         dict_in_word_ff     <= 1'b0;
         dict_word_count_ff  <= '0;
         dict_char_count_ff  <= '0;
      end else begin
         sentence_in_word_ff <= sentence_in_word_in;
         letter_taken_ff     <= letter_taken_in;
         overflow_seen_ff    <= overflow_seen_in;
         dict_in_word_ff     <= dict_in_word_in;
         dict_word_count_ff  <= dict_word_count_in;
         dict_char_count_ff  <= dict_char_count_in;
      end
   end

   // Chain of letter cells
   generate
      for (genvar i = 0; i < LETTER_DEPTH; i++) begin : g_cell
         logic occ_prev, occ_next, live_prev;
         if (i == 0) begin : g_head
            assign occ_prev  = 1'b1;
            assign live_prev = 1'b0;
         end else begin : g_body
            assign occ_prev  = occ[i-1];
            assign live_prev = live[i-1];
         end
         if (i == LETTER_DEPTH - 1) begin : g_end
            assign occ_next = 1'b0;
         end else begin : g_mid
            assign occ_next = occ[i+1];
         end
         acsm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .occ_prev  (occ_prev),
            .occ_next  (occ_next),
            .live_prev (live_prev),
            .occ       (occ[i]),
            .live      (live[i])
         );
      end
   endgenerate

   // Live-bit reduction, in step with the tag pipeline
   acsm_or_tree #(.WIDTH(LETTER_DEPTH)) u_tree (
      .clock   (clock),
      .enable  (advance),
      .bits_in (live),
      .any_out (tree_any)
   );

   always_comb begin
      new_tag.valid       = finish;
      new_tag.word_number = dict_word_count_ff;
      new_tag.word_size   = char_count_upd;
      new_tag.overflowed  = overflow_seen_ff;
   end

   // Tag pipeline: stage k lines up with tree level k
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= TREE_LEVELS; k++) begin
            tag_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         tag_ff[0] <= new_tag;
         for (int k = 1; k <= TREE_LEVELS; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         if (out_valid_ff && !rsp_chan.ready) begin
            skid_valid_ff <= tag_ff[TREE_LEVELS].valid;
            skid_tag_ff   <= tag_ff[TREE_LEVELS];
            skid_found_ff <= tree_any;
         end else begin
            out_valid_ff <= tag_ff[TREE_LEVELS].valid;
            out_tag_ff   <= tag_ff[TREE_LEVELS];
            out_found_ff <= tree_any;
         end
      end else if (rsp_chan.ready) begin
         out_valid_ff  <= 1'b1;
         out_tag_ff    <= skid_tag_ff;
         out_found_ff  <= skid_found_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.word_number        = out_tag_ff.word_number;
   assign rsp_chan.word_size          = out_tag_ff.word_size;
   assign rsp_chan.found              = out_found_ff;
   assign rsp_chan.letters_overflowed = out_tag_ff.overflowed;

endmodule

### design/acsm_checker.sv
// Port-level checks for the acrostic substring match top level, and the
// bind that attaches them. Depends on acrostic_substring_match_top.
module acsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_word_number,
   input logic [15:0] rsp_word_size,
   input logic        rsp_found,
   input logic        rsp_letters_overflowed
);

   // Reset empties the output side and opens the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("output not empty after reset");

   // Input backpressure only while a result is waiting
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

   // Every finished word holds at least one byte
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_size != 16'd0))
      else $error("result item with empty word");

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word_number)
         && $stable(rsp_word_size) && $stable(rsp_found)
         && $stable(rsp_letters_overflowed)))
      else $error("stalled result item changed");

   // After an accepted item the input stays open unless a result is waiting
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_valid || req_ready))
      else $error("input closed with no result waiting");

endmodule

bind acrostic_substring_match_top acsm_checker u_acsm_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_chan.valid),
   .req_ready              (req_chan.ready),
   .rsp_valid              (rsp_chan.valid),
   .rsp_ready              (rsp_chan.ready),
   .rsp_word_number        (rsp_chan.word_number),
   .rsp_word_size          (rsp_chan.word_size),
   .rsp_found              (rsp_chan.found),
   .rsp_letters_overflowed (rsp_chan.letters_overflowed)
);

### test/tb.sv
// Testbench for acrostic_substring_match_top: directed byte table, then random sentence and
// dictionary traffic with bursty input and stalling output.
// Depends on acsm_pkg, acsm_ifs and the RTL of the block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import acsm_pkg::*;

   localparam int LETTER_DEPTH = 256;
   localparam int RANDOM_ITEMS = 1050;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_MAX   = 10;
   localparam opcode_type OP_UNUSED = 2'd3;

   typedef struct packed {
      opcode_type opcode;
      char_type   char_byte;
      logic       line_end;
   } byte_item_type;

   typedef struct packed {
      count_type word_number;
      count_type word_size;
      logic      found;
      logic      letters_overflowed;
   } word_result_type;

   typedef struct {
      byte_item_type   item;
      bit              typed;
      word_result_type res;
   } table_row_type;

   logic clock;
   logic reset;

   acsm_req_if req_if ();
   acsm_rsp_if rsp_if ();

   acrostic_substring_match_top #(.LETTER_DEPTH(LETTER_DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow state of the matcher
   char_type                ltr_store [LETTER_DEPTH];
   int unsigned             ltr_count;
   logic [LETTER_DEPTH-1:0] live_bits;
   bit                      snt_in_word;
   bit                      ltr_taken;
   bit                      dct_in_word;
   bit                      ovf_seen;
   count_type               dct_words;
   count_type               dct_chars;

   word_result_type pending_words [$];
   table_row_type   directed_rows [$];
   byte_item_type   episode_bytes [$];

   int unsigned sent_items;
   int unsigned err_count;
   int          burst_left;
   bit          hold_req;

   function automatic bit ascii_alpha(input char_type c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic char_type fold_upper(input char_type c);
      return (c >= 8'h41 && c <= 8'h5A) ? char_type'(c | 8'h20) : c;
   endfunction

   function automatic void clear_matcher();
      int i;
      for (i = 0; i < LETTER_DEPTH; i++) ltr_store[i] = NO_LETTER;
      live_bits   = '0;
      ltr_count   = 0;
      snt_in_word = 1'b0;
      ltr_taken   = 1'b0;
      dct_in_word = 1'b0;
      ovf_seen    = 1'b0;
      dct_words   = '0;
      dct_chars   = '0;
   endfunction

   // Sentence byte: open a slot per word, keep its first letter
   function automatic void take_sentence_byte(input char_type c);
      if (c == SPACE_BYTE) begin
         snt_in_word = 1'b0;
      end else begin
         if (!snt_in_word) begin
            snt_in_word = 1'b1;
            if (ltr_count < LETTER_DEPTH) begin
               ltr_store[ltr_count] = NO_LETTER;
               ltr_count++;
               ltr_taken = 1'b0;
            end else begin
               ovf_seen  = 1'b1;
               ltr_taken = 1'b1;
            end
         end
         if (!ltr_taken && ascii_alpha(c) && ltr_count > 0) begin
            ltr_store[ltr_count-1] = fold_upper(c);
            ltr_taken = 1'b1;
         end
      end
   endfunction

   // Dictionary byte: one Shift-And step over the stored letters
   function automatic void shift_live(input char_type c);
      logic [LETTER_DEPTH-1:0] nxt;
      char_type lc;
      bit prev;
      bit hit;
      int i;
      lc  = fold_upper(c);
      nxt = '0;
      for (i = 0; i < ltr_count; i++) begin
         prev   = !dct_in_word ? 1'b1 : (i == 0 ? 1'b0 : live_bits[i-1]);
         hit    = (ltr_store[i] != NO_LETTER) && (ltr_store[i] == lc);
         nxt[i] = prev && hit;
      end
      live_bits   = nxt;
      dct_in_word = 1'b1;
      if (dct_chars != COUNT_MAX) dct_chars++;
   endfunction

   function automatic word_result_type close_dict_word();
      word_result_type r;
      int i;
      r.found = 1'b0;
      for (i = 0; i < ltr_count; i++)
         if (live_bits[i]) r.found = 1'b1;
      r.word_number        = dct_words;
      r.word_size          = dct_chars;
      r.letters_overflowed = ovf_seen;
      if (dct_words != COUNT_MAX) dct_words++;
      dct_chars   = '0;
      dct_in_word = 1'b0;
      return r;
   endfunction

   // Advance the shadow state by one item; returns 1 when a word result is due
   function automatic bit predict_word_result(input byte_item_type it,
                                              output word_result_type r);
      bit has;
      has = 1'b0;
      r   = '0;
      case (it.opcode)
         OP_SENTENCE: begin
            take_sentence_byte(it.char_byte);
            if (it.line_end) snt_in_word = 1'b0;
         end
         OP_DICT: begin
            if (it.char_byte == SPACE_BYTE) begin
               if (dct_in_word) begin
                  r   = close_dict_word();
                  has = 1'b1;
               end
            end else begin
               shift_live(it.char_byte);
               if (it.line_end) begin
                  r   = close_dict_word();
                  has = 1'b1;
               end
            end
         end
         OP_CLEAR: clear_matcher();
         default: ;
      endcase
      return has;
   endfunction

   function automatic void add_row(input opcode_type op, input char_type c, input logic le);
      table_row_type row;
      row.item  = '{op, c, le};
      row.typed = 1'b0;
      row.res   = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(input opcode_type op, input char_type c, input logic le,
                                     input word_result_type res);
      table_row_type row;
      row.item  = '{op, c, le};
      row.typed = 1'b1;
      row.res   = res;
      directed_rows.push_back(row);
   endfunction

   function automatic void queue_byte(input opcode_type op, input char_type c, input logic le);
      byte_item_type it;
      it = '{op, c, le};
      episode_bytes.push_back(it);
   endfunction

   // Letters from a narrow alphabet so that words often match
   function automatic char_type rand_letter();
      char_type c;
      c = char_type'(8'h61 + $urandom_range(0, 4));
      if ($urandom_range(0, 1)) c = char_type'(c - 8'h20);
      return c;
   endfunction

   function automatic char_type rand_other();
      case ($urandom_range(0, 3))
         0: return char_type'(8'h30 + $urandom_range(0, 9));
         1: return NO_LETTER;
         2: return char_type'($urandom_range(8'h80, 8'hFF));
         default: return char_type'(8'h21 + $urandom_range(0, 30));
      endcase
   endfunction

   // Drive one item, wait for acceptance, record what it should cause
   task automatic send_byte(input byte_item_type it, input bit typed,
                            input word_result_type typed_res);
      word_result_type r;
      int gap;
      req_if.valid     <= 1'b1;
      req_if.opcode    <= it.opcode;
      req_if.char_byte <= it.char_byte;
      req_if.line_end  <= it.line_end;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (predict_word_result(it, r)) pending_words.push_back(typed ? typed_res : r);
      sent_items++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_if.valid     <= 1'b0;
         req_if.opcode    <= opcode_type'($urandom);
         req_if.char_byte <= char_type'($urandom);
         req_if.line_end  <= 1'($urandom);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic play_episode();
      byte_item_type it;
      while (episode_bytes.size() != 0) begin
         it = episode_bytes.pop_front();
         send_byte(it, 1'b0, '0);
      end
   endtask

   // Sentence of a few words, with leading and repeated spaces at random
   function automatic void build_sentence(input int nwords);
      int w;
      int k;
      int len;
      int sp;
      bit ends;
      ends = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) == 0) queue_byte(OP_SENTENCE, SPACE_BYTE, 1'b0);
      for (w = 0; w < nwords; w++) begin
         len = $urandom_range(1, 5);
         for (k = 0; k < len; k++)
            queue_byte(OP_SENTENCE, ($urandom_range(0, 5) == 0) ? rand_other() : rand_letter(),
                       ends && w == nwords - 1 && k == len - 1);
         if (w != nwords - 1) begin
            sp = $urandom_range(1, 3);
            for (k = 0; k < sp; k++) queue_byte(OP_SENTENCE, SPACE_BYTE, 1'b0);
         end
      end
   endfunction

   // Dictionary line, mostly slices of the stored letters in mixed case
   function automatic void build_dict_line();
      int nwords;
      int w;
      int k;
      int len;
      int start;
      int idx;
      bit slice;
      bit last;
      char_type c;
      nwords = $urandom_range(1, 6);
      for (w = 0; w < nwords; w++) begin
         len   = $urandom_range(1, 4);
         slice = ltr_count > 0 && $urandom_range(0, 3) != 0;
         start = slice ? $urandom_range(0, ltr_count - 1) : 0;
         for (k = 0; k < len; k++) begin
            idx = start + k;
            if (slice && idx < ltr_count && ltr_store[idx] != NO_LETTER) begin
               c = ltr_store[idx];
               if ($urandom_range(0, 1)) c = char_type'(c - 8'h20);
               if ($urandom_range(0, 9) == 0) c = rand_letter();
            end else begin
               c = ($urandom_range(0, 4) == 0) ? rand_other() : rand_letter();
            end
            if (c == SPACE_BYTE) c = rand_letter();
            last = (w == nwords - 1) && (k == len - 1) && $urandom_range(0, 2) != 0;
            queue_byte(OP_DICT, c, last);
         end
         if (!last) begin
            queue_byte(OP_DICT, SPACE_BYTE, 1'b0);
            if ($urandom_range(0, 3) == 0) queue_byte(OP_DICT, SPACE_BYTE, 1'b0);
         end
      end
   endfunction

   function automatic void build_noise();
      int n;
      int k;
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++)
         queue_byte(opcode_type'($urandom_range(0, 3)), char_type'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
   endfunction

   // Result checker
   always @(posedge clock) begin
      word_result_type got;
      word_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.word_number, rsp_if.word_size, rsp_if.found, rsp_if.letters_overflowed};
         if (pending_words.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_MAX)
               $display("unexpected word result: number %0d size %0d found %0b ovf %0b",
                        got.word_number, got.word_size, got.found, got.letters_overflowed);
         end else begin
            want = pending_words.pop_front();
            if (got.word_number != want.word_number || got.word_size != want.word_size ||
                got.found != want.found || got.letters_overflowed != want.letters_overflowed) begin
               err_count++;
               if (err_count <= REPORT_MAX)
                  $display("word result mismatch: exp num %0d size %0d found %0b ovf %0b,",
                           want.word_number, want.word_size, want.found,
                           want.letters_overflowed,
                           " got num %0d size %0d found %0b ovf %0b",
                           got.word_number, got.word_size, got.found,
                           got.letters_overflowed);
            end
         end
      end
   end

   // Watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      int idle;
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle = 0;
      end else begin
         idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Result-side stall pattern, with one long hold-off on request
   initial begin : rsp_pacer
      int mode;
      int left;
      int hold_left;
      int cyc;
      bit hold_done;
      mode      = 0;
      left      = 0;
      hold_left = 0;
      cyc       = 0;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(10, 80);
         end
         left--;
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (mode == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            case (mode)
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= (cyc % 4) == 0;
               default: rsp_if.ready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   // Main stimulus
   initial begin : stimulus
      int unsigned rand_start;
      int unsigned n;
      int kind;
      int k;
      bit big_done;
      bit press_done;
      table_row_type row;
      word_result_type empty_word;

      sent_items = 0;
      err_count  = 0;
      burst_left = $urandom_range(1, 40);
      hold_req   = 1'b0;
      big_done   = 1'b0;
      press_done = 1'b0;
      empty_word = '{16'd0, 16'd1, 1'b0, 1'b0};
      clear_matcher();

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.opcode    = OP_SENTENCE;
      req_if.char_byte = '0;
      req_if.line_end  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty store, spacing, no-letter word, high bytes, appending mid-word
      add_typed(OP_DICT, 8'h61, 1'b1, empty_word);
      add_row(OP_SENTENCE, 8'h48, 1'b0);
      add_row(OP_SENTENCE, 8'h69, 1'b0);
      add_row(OP_SENTENCE, SPACE_BYTE, 1'b0);
      add_row(OP_SENTENCE, SPACE_BYTE, 1'b0);
      add_row(OP_SENTENCE, 8'h39, 1'b0);
      add_row(OP_SENTENCE, 8'h00, 1'b0);
      add_row(OP_SENTENCE, SPACE_BYTE, 1'b0);
      add_row(OP_SENTENCE, 8'hC1, 1'b0);
      add_row(OP_SENTENCE, 8'h5A, 1'b1);
      add_row(OP_DICT, 8'h48, 1'b0);
      add_row(OP_DICT, 8'h5A, 1'b1);
      add_row(OP_DICT, 8'h00, 1'b1);
      add_row(OP_DICT, 8'h68, 1'b0);
      add_row(OP_DICT, SPACE_BYTE, 1'b0);
      add_row(OP_DICT, SPACE_BYTE, 1'b0);
      add_row(OP_UNUSED, 8'hFF, 1'b1);
      add_row(OP_DICT, 8'h7A, 1'b0);
      add_row(OP_SENTENCE, 8'h51, 1'b1);
      add_row(OP_DICT, 8'h71, 1'b1);
      add_row(OP_DICT, 8'hFF, 1'b1);
      add_row(OP_CLEAR, 8'h00, 1'b0);
      add_typed(OP_DICT, 8'h61, 1'b1, empty_word);
      add_row(OP_SENTENCE, 8'h61, 1'b1);
      add_row(OP_DICT, 8'h41, 1'b0);
      add_row(OP_DICT, 8'h61, 1'b1);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_byte(row.item, row.typed, row.res);
      end

      // Random traffic
      rand_start = sent_items;
      while (sent_items - rand_start < RANDOM_ITEMS) begin
         n = sent_items - rand_start;
         if (!press_done && n >= 150) begin
            // Output held off while one-byte words keep coming
            press_done = 1'b1;
            hold_req   = 1'b1;
            for (k = 0; k < 40; k++) queue_byte(OP_DICT, rand_letter(), 1'b1);
         end else if (!big_done && n >= 300) begin
            // Fill the store exactly, search it, then push it past its depth
            big_done = 1'b1;
            queue_byte(OP_CLEAR, 8'h00, 1'b0);
            for (k = 0; k < LETTER_DEPTH; k++) begin
               queue_byte(OP_SENTENCE, rand_letter(), k == LETTER_DEPTH - 1);
               if (k != LETTER_DEPTH - 1) queue_byte(OP_SENTENCE, SPACE_BYTE, 1'b0);
            end
            play_episode();
            build_dict_line();
            play_episode();
            build_sentence($urandom_range(1, 20));
            play_episode();
            build_dict_line();
         end else if (ltr_count > 80) begin
            queue_byte(OP_CLEAR, char_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
               queue_byte(OP_CLEAR, char_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (kind < 40)
               build_sentence($urandom_range(1, 10));
            else if (kind < 88)
               build_dict_line();
            else
               build_noise();
         end
         play_episode();
      end
      req_if.valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && pending_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
